>>> hw/rtl/eth_pkg.sv
// Shared constants, types and state codes of the Taylor exponential block.
package eth_pkg;

  localparam int XW               = 16;
  localparam int AW               = 32;
  localparam int DEGW             = 5;
  localparam int DEG_RESET        = 10;
  localparam int MAX_DEGREE       = 31;
  localparam int X_FRAC_BITS      = 12;
  localparam int RESULT_FRAC_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hw/rtl/eth_div.sv
// Radix-2 restoring divider: unsigned dividend by a narrow unsigned divisor.
module eth_div #(
  parameter int DW = 36,
  parameter int KW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        dividend_i,
  input  logic [KW-1:0]        divisor_i,
  output logic [DW-1:0]        quotient_o,
  output eth_pkg::div_status_t status_o
);

  localparam int CW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [KW-1:0] rem_q;
  logic [KW-1:0] div_q;
  logic [DW-1:0] quo_q;

  logic [KW:0] trial;
  logic [KW:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[KW-1:0] : trial[KW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> hw/rtl/exp_taylor_horner.sv
// Top level: Horner evaluation of the Taylor series of e^x with one shared divider.
//
// Input channel: x_value_i (signed Q3.12) moves on a transfer when in_valid_i
// is high and in_stall_o is low. Output channel: exp_result_o (signed Q15.16,
// saturated to 32 bits) and overflow_o move when out_valid_o is high and
// out_stall_i is low. cfg_we_i writes cfg_wdata_i into the degree register;
// degree values above MAX_DEGREE act as MAX_DEGREE, degree 0 gives 0.
//
// Each Horner step passes through ST_MUL (multiply), ST_START (launch the
// divider) and ST_WAIT, where the one-bit-per-cycle divider by k works out
// PW quotient bits (PW = 48 - X_FRAC_BITS, 36 by default) and its quotient
// is taken when it signals done. One item is in work at a time and
// in_stall_o is high until it finishes. The finished result sits in an
// output register, so the next item is taken while the result waits; a
// stalled receiver only holds up the item after that, in its finish state.
//
// Reset: degree returns to 10, the sequencer goes idle, no result is valid.
module exp_taylor_horner #(
  parameter int MAX_DEGREE       = eth_pkg::MAX_DEGREE,
  parameter int X_FRAC_BITS      = eth_pkg::X_FRAC_BITS,
  parameter int RESULT_FRAC_BITS = eth_pkg::RESULT_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eth_pkg::DEGW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [eth_pkg::XW-1:0]  x_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [eth_pkg::AW-1:0]  exp_result_o,
  output logic                           overflow_o
);

  localparam int XW   = eth_pkg::XW;
  localparam int AW   = eth_pkg::AW;
  localparam int DEGW = eth_pkg::DEGW;
  localparam int MW   = XW + AW;                 // full product width
  localparam int PW   = MW - X_FRAC_BITS;        // shifted product width
  localparam int KW   = $clog2(MAX_DEGREE + 1);  // step counter width
  localparam int VW   = PW + 2;                  // 1.0 + quotient, before saturation
  localparam int CMPW = ((DEGW > KW) ? DEGW : KW) + 1;

  localparam logic [CMPW-1:0] MAX_DEG_C = CMPW'(MAX_DEGREE);
  localparam logic signed [VW-1:0] ONE_FX =
    {{(VW-RESULT_FRAC_BITS-1){1'b0}}, 1'b1, {RESULT_FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] SAT_HI = {{(VW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = {{(VW-AW+1){1'b1}}, {(AW-1){1'b0}}};

  eth_pkg::state_e state_q, state_d;

  logic [DEGW-1:0]        deg_q;
  logic                   out_valid_q;
  logic signed [AW-1:0]   res_q;
  logic                   res_ovf_q;

  logic signed [XW-1:0]   x_q;
  logic signed [AW-1:0]   acc_q;
  logic                   ovf_q;
  logic [KW-1:0]          k_q;
  logic signed [MW-1:0]   prod_q;
  logic                   neg_q;

  // degree clamp
  logic [CMPW-1:0] deg_ext, deg_lim;
  logic [KW-1:0]   kdeg;

  assign deg_ext = CMPW'(deg_q);
  assign deg_lim = (deg_ext > MAX_DEG_C) ? MAX_DEG_C : deg_ext;
  assign kdeg    = deg_lim[KW-1:0];

  // multiply and floor shift (arithmetic shift rounds toward -inf)
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] prod_sh;
  logic signed [PW-1:0] p;
  logic [PW-1:0]        p_mag;

  assign prod    = MW'(x_q) * MW'(acc_q);
  assign prod_sh = prod_q >>> X_FRAC_BITS;
  assign p       = prod_sh[PW-1:0];
  assign p_mag   = p[PW-1] ? PW'(-p) : PW'(p);

  // shared divider, |p| / k
  logic                 div_start;
  logic [PW-1:0]        quo;
  eth_pkg::div_status_t div_st;

  eth_div #(
    .DW(PW),
    .KW(KW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(p_mag),
    .divisor_i (k_q),
    .quotient_o(quo),
    .status_o  (div_st)
  );

  // signed truncated quotient, add 1.0, saturate
  logic signed [PW:0]   q_mag;
  logic signed [PW:0]   q_s;
  logic signed [VW-1:0] v;
  logic signed [AW-1:0] acc_next;
  logic                 sat;

  assign q_mag = {1'b0, quo};
  assign q_s   = neg_q ? -q_mag : q_mag;
  assign v     = {q_s[PW], q_s} + ONE_FX;

  always_comb begin
    sat      = 1'b0;
    acc_next = v[AW-1:0];
    if (v > SAT_HI) begin
      sat      = 1'b1;
      acc_next = SAT_HI[AW-1:0];
    end else if (v < SAT_LO) begin
      sat      = 1'b1;
      acc_next = SAT_LO[AW-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      eth_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kdeg == '0) ? eth_pkg::ST_FIN : eth_pkg::ST_MUL;
        end
      end
      eth_pkg::ST_MUL: begin
        state_d = eth_pkg::ST_START;
      end
      eth_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = eth_pkg::ST_WAIT;
      end
      eth_pkg::ST_WAIT: begin
        if (div_st.done) begin
          state_d = (k_q == KW'(1)) ? eth_pkg::ST_FIN : eth_pkg::ST_MUL;
        end
      end
      eth_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = eth_pkg::ST_IDLE;
        end
      end
      default: state_d = eth_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eth_pkg::ST_IDLE;
      deg_q       <= DEGW'(eth_pkg::DEG_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        deg_q <= cfg_wdata_i;
      end
      if (state_q == eth_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == eth_pkg::ST_IDLE && in_valid_i) begin
      x_q   <= x_value_i;
      acc_q <= '0;
      ovf_q <= 1'b0;
      k_q   <= kdeg;
    end
    if (state_q == eth_pkg::ST_MUL) begin
      prod_q <= prod;
    end
    if (state_q == eth_pkg::ST_START) begin
      neg_q <= p[PW-1];
    end
    if (state_q == eth_pkg::ST_WAIT && div_st.done) begin
      acc_q <= acc_next;
      ovf_q <= ovf_q | sat;
      k_q   <= k_q - KW'(1);
    end
    if (state_q == eth_pkg::ST_FIN && out_free) begin
      res_q     <= acc_q;
      res_ovf_q <= ovf_q;
    end
  end

  assign in_stall_o   = (state_q != eth_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign exp_result_o = res_q;
  assign overflow_o   = res_ovf_q;

`ifndef NO_ASSERTIONS
  // the divider only runs while the sequencer waits on it
  a_div_busy_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == eth_pkg::ST_WAIT))
    else $error("divider busy outside wait state");

  // a multiply step never starts with the step counter at zero
  a_k_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eth_pkg::ST_MUL) |-> (k_q != '0))
    else $error("Horner step with k equal to zero");

  // a new result appears only out of the finish state
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == eth_pkg::ST_FIN))
    else $error("result valid without finishing an item");
`endif

endmodule
